@@ hw/rtl/jsu_pkg.sv @@
package jsu_pkg;

	// Input item: one byte of JSON text with its flags
	typedef struct packed {
		logic [7:0] text_byte;
		logic       start_flag;
		logic       end_of_text;
	} text_item_t;

	// Result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last;
	} result_item_t;

	// Result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Decoder phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_STR    = 4'd1,
		PH_ESC    = 4'd2,
		PH_HEX    = 4'd3,
		PH_HP     = 4'd4,
		PH_HP_ESC = 4'd5,
		PH_LOWHEX = 4'd6
	} phase_t;

	// What follows the code points of one command
	typedef enum logic [1:0] {
		TAIL_NONE = 2'd0,
		TAIL_BYTE = 2'd1,
		TAIL_DONE = 2'd2,
		TAIL_ERR  = 2'd3
	} tail_t;

	// Back-end sequencer segments
	typedef enum logic [1:0] {
		SEG_A = 2'd0,
		SEG_B = 2'd1,
		SEG_T = 2'd2
	} seg_t;

	// Command from front to back: up to two code points, then a tail
	typedef struct packed {
		logic        has_a;
		logic [20:0] cp_a;
		logic        has_b;
		logic [15:0] cp_b;
		tail_t       tail;
		logic [7:0]  tail_byte;
	} cmd_t;

	// Characters
	localparam logic [7:0] CHR_QUOTE  = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5c;
	localparam logic [7:0] CHR_SLASH  = 8'h2f;
	localparam logic [7:0] CHR_B      = 8'h62;
	localparam logic [7:0] CHR_F      = 8'h66;
	localparam logic [7:0] CHR_N      = 8'h6e;
	localparam logic [7:0] CHR_R      = 8'h72;
	localparam logic [7:0] CHR_T      = 8'h74;
	localparam logic [7:0] CHR_U      = 8'h75;

	// Surrogate ranges and code point offsets
	localparam logic [15:0] SUR_HI_MIN = 16'hd800;
	localparam logic [15:0] SUR_HI_MAX = 16'hdbff;
	localparam logic [15:0] SUR_LO_MIN = 16'hdc00;
	localparam logic [15:0] SUR_LO_MAX = 16'hdfff;
	localparam logic [20:0] CP_SUPP    = 21'h10000;
	localparam logic [20:0] CP_MAX1    = 21'h7f;
	localparam logic [20:0] CP_MAX2    = 21'h7ff;
	localparam logic [20:0] CP_MAX3    = 21'hffff;

	// UTF-8 lead and continuation marks
	localparam logic [7:0] UTF_LEAD2 = 8'hc0;
	localparam logic [7:0] UTF_LEAD3 = 8'he0;
	localparam logic [7:0] UTF_LEAD4 = 8'hf0;
	localparam logic [7:0] UTF_CONT  = 8'h80;

	// Number of UTF-8 bytes for a code point
	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp <= CP_MAX1) n = 3'd1;
		else if (cp <= CP_MAX2) n = 3'd2;
		else if (cp <= CP_MAX3) n = 3'd3;
		else n = 3'd4;
		return n;
	endfunction

	// One UTF-8 byte of a code point
	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
		logic [7:0] r;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		c0 = UTF_CONT | {2'b00, cp[5:0]};
		c1 = UTF_CONT | {2'b00, cp[11:6]};
		c2 = UTF_CONT | {2'b00, cp[17:12]};
		case (utf8_len(cp))
			3'd1: r = cp[7:0];
			3'd2: r = (idx == 2'd0) ? (UTF_LEAD2 | {3'b000, cp[10:6]}) : c0;
			3'd3: begin
				case (idx)
					2'd0:    r = UTF_LEAD3 | {4'b0000, cp[15:12]};
					2'd1:    r = c1;
					default: r = c0;
				endcase
			end
			default: begin
				case (idx)
					2'd0:    r = UTF_LEAD4 | {5'b00000, cp[20:18]};
					2'd1:    r = c2;
					2'd2:    r = c1;
					default: r = c0;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/jsu_front.sv @@
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  text_item_t text,
	output logic       cmd_valid,
	output cmd_t       cmd
);

	typedef struct packed {
		logic       ok;
		logic       is_u;
		logic [7:0] value;
	} esc_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  digit_q, digit_n;
	logic [15:0] accum_q, accum_n;
	logic [15:0] hp_q, hp_n;

	logic [7:0]  b;
	logic        err;
	logic [4:0]  hexd;
	logic [15:0] acc_new;
	esc_t        esc;

	// Map a hex digit to its value, with a valid bit on top
	function automatic logic [4:0] hexval(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		else r = 5'd0;
		return r;
	endfunction

	// Decode the letter after a backslash
	function automatic esc_t esc_decode(input logic [7:0] c);
		esc_t r;
		r = '0;
		r.ok = 1'b1;
		unique case (c) inside
			CHR_QUOTE, CHR_BSLASH, CHR_SLASH: r.value = c;
			CHR_B:   r.value = 8'h08;
			CHR_F:   r.value = 8'h0c;
			CHR_N:   r.value = 8'h0a;
			CHR_R:   r.value = 8'h0d;
			CHR_T:   r.value = 8'h09;
			CHR_U:   r.is_u = 1'b1;
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

	assign b       = text.text_byte;
	assign hexd    = hexval(b);
	assign acc_new = {accum_q[11:0], hexd[3:0]};
	assign esc     = esc_decode(b);

	// Classify the byte against the current phase
	always_comb begin
		phase_n = phase_q;
		digit_n = digit_q;
		accum_n = accum_q;
		hp_n    = hp_q;
		cmd     = '0;
		err     = 1'b0;
		if (text.start_flag) begin
			digit_n = 2'd0;
			accum_n = 16'd0;
			hp_n    = 16'd0;
			if (b != CHR_QUOTE) err = 1'b1;
			else phase_n = PH_STR;
		end else begin
			unique case (phase_q)
				PH_STR, PH_HP: begin
					if (phase_q == PH_HP && b == CHR_BSLASH) begin
						phase_n = PH_HP_ESC;
					end else begin
						if (phase_q == PH_HP) begin
							cmd.has_a = 1'b1;
							cmd.cp_a  = {5'b00000, hp_q};
						end
						if (b == CHR_QUOTE) begin
							cmd.tail = TAIL_DONE;
							phase_n  = PH_IDLE;
						end else if (b == CHR_BSLASH) begin
							phase_n = PH_ESC;
						end else begin
							cmd.tail      = TAIL_BYTE;
							cmd.tail_byte = b;
							phase_n       = PH_STR;
						end
					end
				end
				PH_ESC, PH_HP_ESC: begin
					if (phase_q == PH_HP_ESC && b == CHR_U) begin
						phase_n = PH_LOWHEX;
						digit_n = 2'd0;
						accum_n = 16'd0;
					end else begin
						if (phase_q == PH_HP_ESC) begin
							cmd.has_a = 1'b1;
							cmd.cp_a  = {5'b00000, hp_q};
						end
						phase_n = PH_STR;
						if (!esc.ok) begin
							err = 1'b1;
						end else if (esc.is_u) begin
							phase_n = PH_HEX;
							digit_n = 2'd0;
							accum_n = 16'd0;
						end else begin
							cmd.tail      = TAIL_BYTE;
							cmd.tail_byte = esc.value;
						end
					end
				end
				PH_HEX, PH_LOWHEX: begin
					if (!hexd[4]) begin
						err = 1'b1;
					end else begin
						accum_n = acc_new;
						if (digit_q != 2'd3) begin
							digit_n = digit_q + 2'd1;
						end else begin
							digit_n = 2'd0;
							if (phase_q == PH_LOWHEX && acc_new >= SUR_LO_MIN &&
									acc_new <= SUR_LO_MAX) begin
								// Combine the surrogate pair
								cmd.has_a = 1'b1;
								cmd.cp_a  = CP_SUPP + {1'b0, hp_q[9:0], acc_new[9:0]};
								phase_n   = PH_STR;
							end else begin
								// Flush an unpaired high surrogate first
								if (phase_q == PH_LOWHEX) begin
									cmd.has_a = 1'b1;
									cmd.cp_a  = {5'b00000, hp_q};
								end
								if (acc_new >= SUR_HI_MIN && acc_new <= SUR_HI_MAX) begin
									hp_n    = acc_new;
									phase_n = PH_HP;
								end else begin
									if (phase_q == PH_LOWHEX) begin
										cmd.has_b = 1'b1;
										cmd.cp_b  = acc_new;
									end else begin
										cmd.has_a = 1'b1;
										cmd.cp_a  = {5'b00000, acc_new};
									end
									phase_n = PH_STR;
								end
							end
						end
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
		// Drop everything on an error or on text ending inside a string
		if (err || (text.end_of_text && phase_n != PH_IDLE)) begin
			cmd      = '0;
			cmd.tail = TAIL_ERR;
			phase_n  = PH_IDLE;
		end
	end

	assign cmd_valid = accept && (cmd.has_a || cmd.tail != TAIL_NONE);

	// Advance decoder state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			digit_q <= 2'd0;
			accum_q <= 16'd0;
			hp_q    <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			digit_q <= digit_n;
			accum_q <= accum_n;
			hp_q    <= hp_n;
		end
	end

endmodule

@@ hw/rtl/jsu_queue.sv @@
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/jsu_back.sv @@
module jsu_back import jsu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  cmd_t         cmd,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	cmd_t         cur_q;
	logic         cur_valid_q;
	seg_t         seg_q, seg_n;
	logic [1:0]   idx_q;
	logic         out_valid_q;
	result_item_t out_q;

	logic [20:0]  cp_sel;
	logic [2:0]   len;
	logic         cp_end;
	result_item_t res;
	logic         emit;
	logic         load;

	assign cp_sel = (seg_q == SEG_B) ? {5'b00000, cur_q.cp_b} : cur_q.cp_a;
	assign len    = utf8_len(cp_sel);
	assign cp_end = ({1'b0, idx_q} == len - 3'd1);

	// Build the current result and pick the following segment
	always_comb begin
		res   = '0;
		seg_n = SEG_T;
		unique case (seg_q)
			SEG_A: begin
				res.kind     = KIND_BYTE;
				res.out_byte = utf8_byte(cp_sel, idx_q);
				seg_n        = cur_q.has_b ? SEG_B : SEG_T;
				res.last     = cp_end && !cur_q.has_b && cur_q.tail == TAIL_NONE;
			end
			SEG_B: begin
				res.kind     = KIND_BYTE;
				res.out_byte = utf8_byte(cp_sel, idx_q);
				seg_n        = SEG_T;
				res.last     = cp_end && cur_q.tail == TAIL_NONE;
			end
			default: begin
				res.last = 1'b1;
				case (cur_q.tail)
					TAIL_BYTE: begin
						res.kind     = KIND_BYTE;
						res.out_byte = cur_q.tail_byte;
					end
					TAIL_DONE: res.kind = KIND_DONE;
					default:   res.kind = KIND_ERR;
				endcase
			end
		endcase
	end

	assign emit      = cur_valid_q && (!out_valid_q || result_ready);
	assign cmd_ready = !cur_valid_q || (emit && res.last);
	assign load      = cmd_valid && cmd_ready;

	// Step through the command one result per cycle while the output is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			seg_q       <= SEG_A;
			idx_q       <= 2'd0;
		end else if (load) begin
			cur_valid_q <= 1'b1;
			seg_q       <= cmd.has_a ? SEG_A : SEG_T;
			idx_q       <= 2'd0;
		end else if (emit && res.last) begin
			cur_valid_q <= 1'b0;
		end else if (emit) begin
			if (cp_end) begin
				seg_q <= seg_n;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Hold the command being expanded
	always_ff @(posedge clk) begin
		if (load) cur_q <= cmd;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= res;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ hw/rtl/json_string_unescaper.sv @@
// Channel   Direction  Handshake                    Payload
// text      input      text_valid / text_ready      text_item_t   (byte, start, end)
// result    output     result_valid / result_ready  result_item_t (kind, byte, last)
//
// A text byte is taken every cycle while the command queue has room; the
// front decodes it in the cycle it is transferred.
// Results leave one per cycle from the back sequencer while result_ready
// stays high; a byte can cause up to 6 results, so the queue depth sets
// how long a burst the front absorbs before text_ready drops.
// Reset clears the decoder phase, queue pointers and the output valid.
// A stalled result holds in the output register while the back keeps the
// current command and the front keeps filling the queue.
module json_string_unescaper import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         text_valid,
	output logic         text_ready,
	input  text_item_t   text,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	logic accept;
	logic push_valid;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	assign accept = text_valid && text_ready;

	// Classify text bytes into commands
	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text      (text),
		.cmd_valid (push_valid),
		.cmd       (push_cmd)
	);

	// Decouple front and back
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (text_ready),
		.push_data  (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_cmd)
	);

	// Expand commands into UTF-8 results
	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (pop_valid),
		.cmd_ready    (pop_ready),
		.cmd          (pop_cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// An error stands alone and ends its byte's results
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_ERR |-> result.last && result.out_byte == 8'd0)
		else $error("error result not final or carries a byte");

	// Completion ends its byte's results
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_DONE |-> result.last && result.out_byte == 8'd0)
		else $error("completion result not final or carries a byte");

	// Every queued command yields at least one result, second code point only after first
	a_cmd_shape: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (push_cmd.has_a || push_cmd.tail != TAIL_NONE) &&
			(!push_cmd.has_b || push_cmd.has_a))
		else $error("malformed command pushed");

endmodule
